// ===== sv/stt_pkg.sv =====
// Package for the stage text tokenizer: field widths, kinds, codes and item structs.
// No dependencies; used by every other file of the block except stt_stream_if.
package stt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  localparam logic [3:0] K_STRING = 4'd0;
  localparam logic [3:0] K_NUMBER = 4'd1;
  localparam logic [3:0] K_SYMBOL = 4'd2;
  localparam logic [3:0] K_IDENT  = 4'd3;
  localparam logic [3:0] K_SET    = 4'd4;
  localparam logic [3:0] K_STAGE  = 4'd8;
  localparam logic [3:0] K_DIAG   = 4'd9;
  localparam logic [3:0] K_END    = 4'd10;

  localparam logic [2:0] D_NONE    = 3'd0;
  localparam logic [2:0] D_EMPTY   = 3'd1;
  localparam logic [2:0] D_NUL     = 3'd2;
  localparam logic [2:0] D_OPENCOM = 3'd3;
  localparam logic [2:0] D_NLSTR   = 3'd4;
  localparam logic [2:0] D_OPENSTR = 3'd5;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b0000000001,
    M_PEND  = 10'b0000000010,
    M_LCOM  = 10'b0000000100,
    M_BCOM  = 10'b0000001000,
    M_BSTAR = 10'b0000010000,
    M_STR   = 10'b0000100000,
    M_ESC   = 10'b0001000000,
    M_WORD  = 10'b0010000000,
    M_NUM   = 10'b0100000000,
    M_HALT  = 10'b1000000000
  } mode_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  result_kind;
    logic [2:0]  diag_code;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [31:0] column_number;
    logic [7:0]  symbol_char;
    logic        recognized;
    logic        all_ok;
    logic        last_of_run;
  } out_item_t;

  // One entry of the queue between front and back: up to two results.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } pair_t;

  localparam logic [7:0] KW_CH [11][8] = '{
    '{8'h23, "S", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"D", "O", "O", "R", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"B", "O", "X", "I", "N", 8'h0, 8'h0, 8'h0},
    '{"N", "E", "X", "T", "R", "O", "O", "M"},
    '{"D", "U", "M", "M", "Y", 8'h0, 8'h0, 8'h0},
    '{"S", "T", "A", "Y", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"B", "R", "E", "A", "K", 8'h0, 8'h0, 8'h0},
    '{"O", "R", "B", "R", "E", "A", "K", 8'h0},
    '{"S", "E", "A", "L", 8'h0, 8'h0, 8'h0, 8'h0},
    '{"S", "W", "I", "T", "C", "H", 8'h0, 8'h0},
    '{"Y", "U", "R", "E", 8'h0, 8'h0, 8'h0, 8'h0}
  };
  localparam logic [3:0] KW_LEN [11] = '{4'd4, 4'd4, 4'd5, 4'd8, 4'd5, 4'd4,
                                         4'd5, 4'd7, 4'd4, 4'd6, 4'd4};

  function automatic logic [31:0] sat32(input logic [OFFSET_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// ===== sv/stt_stream_if.sv =====
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a type parameter.
interface stt_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/stt_front.sv =====
// Front part: the scanning mode machine; turns one byte or end item into up to two results.
// Depends on stt_pkg.
module stt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  stt_pkg::in_item_t in_data,
  output logic             q_push,
  output stt_pkg::pair_t   q_data,
  input  logic             q_full
);
  import stt_pkg::*;

  mode_t mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, tstart_r, tstart_nxt;
  logic [31:0] line_r, line_nxt, col_r, col_nxt, tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [10:0] kw_r, kw_nxt;
  logic [2:0]  nf_r, nf_nxt;   // [0] decimal, [1] exponent, [2] sign allowed
  logic [2:0]  st_r, st_nxt;   // [0] any, [1] nul, [2] error
  logic        fire;
  out_item_t   r0, r1;
  logic [1:0]  n;
  logic [7:0]  b;
  logic [OFFSET_BITS-1:0] tlen;

  assign in_ready = !q_full;
  assign fire = in_valid && in_ready;
  assign b = in_data.data_byte;

  function automatic logic dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic spc(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic [7:0] upc(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction
  // Narrow the candidate mask by byte c at word position pos.
  function automatic logic [10:0] kmatch(input logic [10:0] m,
                                         input logic [OFFSET_BITS-1:0] pos,
                                         input logic [7:0] c);
    logic [10:0] r;
    r = '0;
    if (pos < OFFSET_BITS'(8)) begin
      for (int i = 0; i < 11; i++) begin
        if (m[i] && pos < OFFSET_BITS'(KW_LEN[i]) && upc(c) == KW_CH[i][pos[2:0]])
          r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Results are composed in two slots; r0 goes out first, r1 second.
  always_comb begin
    logic [3:0] wk;
    logic       set_start;
    logic       do_flush, do_start;
    mode_nxt = mode_r; off_nxt = off_r; line_nxt = line_r; col_nxt = col_r;
    tstart_nxt = tstart_r; tline_nxt = tline_r; tcol_nxt = tcol_r;
    pend_nxt = pend_r; kw_nxt = kw_r; nf_nxt = nf_r; st_nxt = st_r;
    r0 = '0; r1 = '0; n = 2'd0;
    wk = K_IDENT; set_start = 1'b0; do_flush = 1'b0; do_start = 1'b0;
    tlen = off_r - tstart_r;
    for (int i = 10; i >= 0; i--) begin
      if (kw_r[i] && tlen == OFFSET_BITS'(KW_LEN[i]))
        wk = (i < 4) ? K_SET + 4'(i) : K_STAGE;
    end

    if (in_data.opcode == OP_END) begin
      if (!st_r[0]) begin
        r0.result_kind = K_DIAG; r0.diag_code = D_EMPTY;
        r0.line_number = 32'd1; r0.column_number = 32'd1; n = 2'd1;
      end else if (mode_r == M_BCOM || mode_r == M_BSTAR || mode_r == M_STR ||
                   mode_r == M_ESC) begin
        r0.result_kind = K_DIAG;
        r0.diag_code = (mode_r == M_BCOM || mode_r == M_BSTAR) ? D_OPENCOM : D_OPENSTR;
        r0.start_offset = sat32(tstart_r); r0.line_number = tline_r;
        r0.column_number = tcol_r; n = 2'd1;
        st_nxt[2] = 1'b1;
      end else begin
        do_flush = 1'b1;
      end
      if (do_flush && (mode_r == M_PEND || mode_r == M_WORD || mode_r == M_NUM)) begin
        r0.start_offset = sat32(tstart_r); r0.line_number = tline_r;
        r0.column_number = tcol_r;
        if (mode_r == M_PEND) begin
          r0.result_kind = K_SYMBOL; r0.token_length = 32'd1; r0.symbol_char = pend_r;
        end else begin
          r0.result_kind = (mode_r == M_WORD) ? wk : K_NUMBER;
          r0.token_length = sat32(tlen);
        end
        n = 2'd1;
      end
      r1.result_kind = K_END; r1.start_offset = sat32(off_r);
      r1.line_number = line_r; r1.column_number = col_r;
      r1.recognized = st_r[0] && !st_r[1];
      r1.all_ok = st_r[0] && !st_r[1] && !(st_nxt[2]);
      r1.last_of_run = 1'b1;
      if (n == 2'd0) begin
        r0 = r1; r1 = '0; n = 2'd1;
      end else begin
        n = 2'd2;
      end
      mode_nxt = M_IDLE; off_nxt = '0; line_nxt = 32'd1; col_nxt = 32'd1;
      tstart_nxt = '0; tline_nxt = 32'd1; tcol_nxt = 32'd1; pend_nxt = '0;
      kw_nxt = '1; nf_nxt = '0; st_nxt = '0;
    end else begin
      st_nxt[0] = 1'b1;
      if (b == 8'd0) begin
        if (!st_r[1]) begin
          st_nxt[1] = 1'b1;
          r0.result_kind = K_DIAG; r0.diag_code = D_NUL;
          r0.line_number = 32'd1; r0.column_number = 32'd1; n = 2'd1;
        end
        mode_nxt = M_HALT;
      end else begin
        unique case (mode_r)
          M_IDLE: do_start = 1'b1;
          M_PEND: begin
            if (pend_r == "/" && b == "/") mode_nxt = M_LCOM;
            else if (pend_r == "/" && b == "*") mode_nxt = M_BCOM;
            else if (pend_r != "/" && dig(b)) begin
              nf_nxt = '0; mode_nxt = M_NUM;
            end else begin
              do_flush = 1'b1; do_start = 1'b1;
            end
          end
          M_LCOM: if (b == 8'h0A) mode_nxt = M_IDLE;
          M_BCOM, M_BSTAR: begin
            if (mode_r == M_BSTAR && b == "/") mode_nxt = M_IDLE;
            else mode_nxt = (b == "*") ? M_BSTAR : M_BCOM;
          end
          M_STR: begin
            if (b == 8'h22) begin
              r0.result_kind = K_STRING; r0.start_offset = sat32(tstart_r);
              r0.token_length = sat32(tlen == OFF_MAX ? tlen : tlen + 1'b1);
              r0.line_number = tline_r; r0.column_number = tcol_r; n = 2'd1;
              mode_nxt = M_IDLE;
            end else if (b == 8'h5C) begin
              mode_nxt = M_ESC;
            end else if (b == 8'h0A || b == 8'h0D) begin
              r0.result_kind = K_DIAG; r0.diag_code = D_NLSTR;
              r0.start_offset = sat32(tstart_r); r0.line_number = tline_r;
              r0.column_number = tcol_r;
              r1 = r0; r1.diag_code = D_OPENSTR; n = 2'd2;
              st_nxt[2] = 1'b1; mode_nxt = M_HALT;
            end
          end
          M_ESC: mode_nxt = M_STR;
          M_WORD: begin
            if (alp(b) || dig(b) || b == "_") kw_nxt = kmatch(kw_r, tlen, b);
            else begin
              do_flush = 1'b1; do_start = 1'b1;
            end
          end
          M_NUM: begin
            nf_nxt[2] = 1'b0;
            if (nf_r[2] && (b == "+" || b == "-")) begin
            end else if (dig(b)) begin
            end else if (b == "." && nf_r[1:0] == 2'b00) begin
              nf_nxt[0] = 1'b1;
            end else if ((b == "e" || b == "E") && !nf_r[1]) begin
              nf_nxt[1] = 1'b1; nf_nxt[2] = 1'b1;
            end else begin
              do_flush = 1'b1; do_start = 1'b1;
            end
          end
          default: mode_nxt = M_HALT;
        endcase
        if (do_flush) begin
          r0.start_offset = sat32(tstart_r); r0.line_number = tline_r;
          r0.column_number = tcol_r; n = 2'd1;
          if (mode_r == M_PEND) begin
            r0.result_kind = K_SYMBOL; r0.token_length = 32'd1; r0.symbol_char = pend_r;
          end else begin
            r0.result_kind = (mode_r == M_WORD) ? wk : K_NUMBER;
            r0.token_length = sat32(tlen);
          end
        end
        if (do_start) begin
          mode_nxt = M_IDLE;
          if (!spc(b)) begin
            set_start = 1'b1;
            if (b == "/" || b == "+" || b == "-" || b == ".") begin
              pend_nxt = b; mode_nxt = M_PEND;
            end else if (b == 8'h22) begin
              mode_nxt = M_STR;
            end else if (b == "#" || alp(b) || b == "_") begin
              kw_nxt = kmatch(11'h7FF, '0, b); mode_nxt = M_WORD;
            end else if (dig(b)) begin
              nf_nxt = '0; mode_nxt = M_NUM;
            end else begin
              r1.result_kind = K_SYMBOL; r1.token_length = 32'd1; r1.symbol_char = b;
              r1.start_offset = sat32(off_r); r1.line_number = line_r;
              r1.column_number = col_r;
              if (n == 2'd0) begin
                r0 = r1; r1 = '0; n = 2'd1;
              end else n = 2'd2;
            end
          end
        end
        if (set_start) begin
          tstart_nxt = off_r; tline_nxt = line_r; tcol_nxt = col_r;
        end
      end
      if (off_r != OFF_MAX) off_nxt = off_r + 1'b1;
      if (b == 8'h0A) begin
        if (line_r != 32'hFFFF_FFFF) line_nxt = line_r + 32'd1;
        col_nxt = 32'd1;
      end else if (col_r != 32'hFFFF_FFFF) col_nxt = col_r + 32'd1;
      if (n == 2'd1) r0.last_of_run = 1'b1;
      if (n == 2'd2) r1.last_of_run = 1'b1;
    end
  end

  assign q_push = fire && n != 2'd0;
  assign q_data = '{two: n == 2'd2, first: r0, second: r1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; off_r <= '0; line_r <= 32'd1; col_r <= 32'd1;
      tstart_r <= '0; tline_r <= 32'd1; tcol_r <= 32'd1; pend_r <= '0;
      kw_r <= '1; nf_r <= '0; st_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt; off_r <= off_nxt; line_r <= line_nxt; col_r <= col_nxt;
      tstart_r <= tstart_nxt; tline_r <= tline_nxt; tcol_r <= tcol_nxt;
      pend_r <= pend_nxt; kw_r <= kw_nxt; nf_r <= nf_nxt; st_r <= st_nxt;
    end
  end

  a_halt_stays: assert property (@(posedge clk) disable iff (!rst_n)
    fire && mode_r == M_HALT && in_data.opcode == OP_BYTE |=> mode_r == M_HALT)
    else $error("halted scan left halt on a byte");
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.opcode == OP_END |=> off_r == '0 && st_r == '0)
    else $error("end item did not reset the scan");
  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_data.opcode == OP_END |-> q_push)
    else $error("end item produced no result");
endmodule

// ===== sv/stt_back.sv =====
// Back part: a two-entry queue of result pairs, delivered one result per cycle while out_ready is high.
// Depends on stt_pkg.
module stt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  stt_pkg::pair_t    q_data,
  output logic              q_full,
  output logic              out_valid,
  input  logic              out_ready,
  output stt_pkg::out_item_t out_data
);
  import stt_pkg::*;

  pair_t      buf_r [2];
  logic       wp_r, rp_r, half_r;
  logic [1:0] cnt_r;
  logic       pop_item, pop_pair;

  assign q_full    = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = half_r ? buf_r[rp_r].second : buf_r[rp_r].first;
  assign pop_item  = out_valid && out_ready;
  assign pop_pair  = pop_item && (half_r || !buf_r[rp_r].two);

  always_ff @(posedge clk) begin
    if (q_push) buf_r[wp_r] <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; half_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (q_push) wp_r <= !wp_r;
      if (pop_pair) begin
        rp_r <= !rp_r; half_r <= 1'b0;
      end else if (pop_item) half_r <= 1'b1;
      cnt_r <= cnt_r + 2'(q_push) - 2'(pop_pair);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || pop_pair)
    else $error("push into full queue");
  a_half_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> out_valid && buf_r[rp_r].two)
    else $error("second half selected on a single entry");
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    pop_pair |-> out_data.last_of_run)
    else $error("pair retired without last mark");
endmodule

// ===== sv/stage_text_tokenizer.sv =====
// Stage text tokenizer top level: front scanner, result queue, output channel.
// Depends on stt_pkg, stt_stream_if, stt_front and stt_back.
//
// The tokenizer takes one resource byte or end item per cycle and keeps taking
// them back to back as long as its two-entry result queue has room; the scan
// state (mode, position, keyword candidate mask) updates in a single step per
// byte in the front part. An item yields up to two results, queued together
// and sent one per cycle, so a run of two-result items is paced by the output
// port at one result per cycle. Tokens carry kind, start offset, length, line
// and column; the last result of each item has last_of_run set. After a nul
// byte diagnostic, tokens already sent must be dropped downstream.
module stage_text_tokenizer (
  input logic clk,
  input logic rst_n,
  stt_stream_if.sink   in_if,
  stt_stream_if.source out_if
);
  import stt_pkg::*;

  logic  q_push, q_full;
  pair_t q_data;

  stt_front u_front (
    .clk, .rst_n,
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_data  (in_if.data),
    .q_push, .q_data, .q_full
  );

  stt_back u_back (
    .clk, .rst_n,
    .q_push, .q_data, .q_full,
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );
endmodule

// ===== test/stt_tb_checker.sv =====
// Checker for the stage text tokenizer: watches both channels, predicts the
// token stream of each accepted item and compares it with what the block sends.
// Depends on stt_pkg.
`timescale 1ns / 1ps
module stt_tb_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  stt_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  stt_pkg::out_item_t out_data,
  output int   fail_count,
  output int   pending_count
);
  import stt_pkg::*;

  typedef enum int {
    S_IDLE, S_PEND, S_LCOM, S_BCOM, S_BSTAR, S_STR, S_ESC, S_WORD, S_NUM, S_HALT
  } scan_t;

  localparam logic [2:0] NUM_DEC = 3'b001;
  localparam logic [2:0] NUM_EXP = 3'b010;
  localparam logic [2:0] NUM_SIGN = 3'b100;

  scan_t       mode;
  logic [31:0] pos, line, col, tok_pos, tok_line, tok_col;
  logic [7:0]  held;
  logic [10:0] kw_mask;
  logic [2:0]  num_flags;
  logic        seen_any, seen_nul, seen_err;

  out_item_t   expected_tokens[$];
  out_item_t   step_tokens[$];

  assign pending_count = expected_tokens.size();

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit is_alp(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit is_ws(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic clear_scan();
    mode = S_IDLE; pos = 0; line = 1; col = 1;
    tok_pos = 0; tok_line = 1; tok_col = 1;
    held = 0; kw_mask = 11'h7FF; num_flags = 0;
    seen_any = 0; seen_nul = 0; seen_err = 0;
  endtask

  task automatic emit(logic [3:0] kind, logic [2:0] code, logic [31:0] start,
                      logic [31:0] len, logic [31:0] ln, logic [31:0] cl,
                      logic [7:0] sym, logic rec, logic ok);
    out_item_t t;
    t.result_kind = kind; t.diag_code = code; t.start_offset = start;
    t.token_length = len; t.line_number = ln; t.column_number = cl;
    t.symbol_char = sym; t.recognized = rec; t.all_ok = ok; t.last_of_run = 0;
    step_tokens = {step_tokens, t};
  endtask

  task automatic emit_token(logic [3:0] kind, logic [31:0] len, logic [7:0] sym);
    emit(kind, D_NONE, tok_pos, len, tok_line, tok_col, sym, 0, 0);
  endtask

  task automatic emit_diag(logic [2:0] code);
    if (code != D_EMPTY && code != D_NUL) seen_err = 1;
    emit(K_DIAG, code, tok_pos, 0, tok_line, tok_col, 0, 0, 0);
  endtask

  // Narrow the keyword candidates by the byte at the current word position.
  task automatic narrow_keywords(logic [7:0] b);
    logic [31:0] idx;
    logic [10:0] m;
    logic [7:0]  u;
    idx = pos - tok_pos;
    m = 0;
    u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
    if (idx < 8) begin
      for (int i = 0; i < 11; i++) begin
        if (kw_mask[i] && idx < KW_LEN[i] && u == KW_CH[i][idx]) m[i] = 1;
      end
    end
    kw_mask = m;
  endtask

  function automatic logic [3:0] kind_of_word(logic [31:0] len);
    for (int i = 0; i < 11; i++) begin
      if (kw_mask[i] && len == KW_LEN[i]) return (i < 4) ? 4'(4 + i) : K_STAGE;
    end
    return K_IDENT;
  endfunction

  task automatic flush_open();
    logic [31:0] len;
    len = pos - tok_pos;
    case (mode)
      S_PEND: emit_token(K_SYMBOL, 1, held);
      S_WORD: emit_token(kind_of_word(len), len, 0);
      S_NUM:  emit_token(K_NUMBER, len, 0);
      default: ;
    endcase
  endtask

  task automatic begin_token(logic [7:0] b);
    mode = S_IDLE;
    if (!is_ws(b)) begin
      tok_pos = pos; tok_line = line; tok_col = col;
      if (b == "/" || b == "+" || b == "-" || b == ".") begin
        held = b; mode = S_PEND;
      end else if (b == "\"") begin
        mode = S_STR;
      end else if (b == "#" || is_alp(b) || b == "_") begin
        kw_mask = 11'h7FF; narrow_keywords(b); mode = S_WORD;
      end else if (is_dig(b)) begin
        num_flags = 0; mode = S_NUM;
      end else begin
        emit_token(K_SYMBOL, 1, b);
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    logic sign_ok;
    logic [31:0] span;
    seen_any = 1;
    if (b == 8'd0) begin
      if (!seen_nul) begin
        seen_nul = 1;
        emit(K_DIAG, D_NUL, 0, 0, 1, 1, 0, 0, 0);
      end
      mode = S_HALT;
    end else begin
      case (mode)
        S_IDLE: begin_token(b);
        S_PEND: begin
          if (held == "/" && b == "/") mode = S_LCOM;
          else if (held == "/" && b == "*") mode = S_BCOM;
          else if (held != "/" && is_dig(b)) begin
            num_flags = 0; mode = S_NUM;
          end else begin
            flush_open(); begin_token(b);
          end
        end
        S_LCOM: if (b == "\n") mode = S_IDLE;
        S_BCOM, S_BSTAR: begin
          if (mode == S_BSTAR && b == "/") mode = S_IDLE;
          else mode = (b == "*") ? S_BSTAR : S_BCOM;
        end
        S_STR: begin
          if (b == "\"") begin
            // The length with both quotes saturates at the field maximum.
            span = pos - tok_pos;
            emit_token(K_STRING, (span == 32'hFFFF_FFFF) ? span : span + 1, 0);
            mode = S_IDLE;
          end else if (b == "\\") begin
            mode = S_ESC;
          end else if (b == "\n" || b == "\r") begin
            emit_diag(D_NLSTR); emit_diag(D_OPENSTR); mode = S_HALT;
          end
        end
        S_ESC: mode = S_STR;
        S_WORD: begin
          if (is_alp(b) || is_dig(b) || b == "_") narrow_keywords(b);
          else begin
            flush_open(); begin_token(b);
          end
        end
        S_NUM: begin
          sign_ok = num_flags[2];
          num_flags &= ~NUM_SIGN;
          if ((sign_ok && (b == "+" || b == "-")) || is_dig(b)) begin
          end else if (b == "." && (num_flags & (NUM_DEC | NUM_EXP)) == 0) begin
            num_flags |= NUM_DEC;
          end else if ((b == "e" || b == "E") && (num_flags & NUM_EXP) == 0) begin
            num_flags |= NUM_EXP | NUM_SIGN;
          end else begin
            flush_open(); begin_token(b);
          end
        end
        default: mode = S_HALT;
      endcase
    end
    if (pos != 32'hFFFF_FFFF) pos++;
    if (b == "\n") begin
      if (line != 32'hFFFF_FFFF) line++;
      col = 1;
    end else if (col != 32'hFFFF_FFFF) begin
      col++;
    end
  endtask

  task automatic take_end();
    logic rec;
    if (!seen_any) emit(K_DIAG, D_EMPTY, 0, 0, 1, 1, 0, 0, 0);
    else if (mode == S_BCOM || mode == S_BSTAR) emit_diag(D_OPENCOM);
    else if (mode == S_STR || mode == S_ESC) emit_diag(D_OPENSTR);
    else flush_open();
    rec = seen_any && !seen_nul;
    emit(K_END, D_NONE, pos, 0, line, col, 0, rec, rec && !seen_err);
    clear_scan();
  endtask

  task automatic report(string what, out_item_t exp_t, out_item_t act_t);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s): expected %p, got %p", what, exp_t, act_t);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_scan();
      expected_tokens.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        step_tokens.delete();
        if (in_data.opcode == OP_END) take_end();
        else take_byte(in_data.data_byte);
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1;
        expected_tokens = {expected_tokens, step_tokens};
      end
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report("unexpected result", '0, out_data);
        end else begin
          want = expected_tokens.pop_front();
          if (want !== out_data) report("field differs", want, out_data);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

// ===== test/stage_text_tokenizer_tb.sv =====
// Testbench top for the stage text tokenizer: clock, reset, item stimulus and
// verdict. Depends on stt_pkg, stt_stream_if, the block and stt_tb_checker.
`timescale 1ns / 1ps
module stage_text_tokenizer_tb;
  import stt_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;

  stt_stream_if #(.item_t(in_item_t))  in_if ();
  stt_stream_if #(.item_t(out_item_t)) out_if ();

  stage_text_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  stt_tb_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_data       (in_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_data      (out_if.data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Fragments that reach deep into the scanner: keywords in mixed case,
  // numbers with signs, points and exponents, strings with escapes, comments.
  string snippets[] = '{
    "#set", "DoOr", "boxin", "NextRoom", "dummy", "stay", "break", "OrBreak",
    "seal", "switch", "yure", "doors", "nextroomx", "ident_9", "#x",
    "12", "-3.5e+7", "+.5", ".25E-3", "1e5e", "1.2.3", "7e-", "--1",
    "\"a\\\"b\"", "\"plain\"", "\"\\\\\"", "// note\n", "/* x * / ** */",
    "/**/", "\n", "\t \r ", "{", ";", "=", "/", "+", "-", ".", "a/b", "x.y"
  };

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sink side: ready may drop after each result, with calm
  // stretches where it stays high.
  initial begin
    int gap;
    out_if.ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_if.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Hands one item to the block and waits until it is accepted. Valid stays
  // high after acceptance so that the next item can follow without a gap.
  task automatic send_item(logic op, logic [7:0] b);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1;
    in_if.data  <= '{opcode: op, data_byte: b};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i]);
  endtask

  int sent;

  initial begin
    string s;
    in_if.valid = 0;
    in_if.data  = '0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part: empty resource, keywords, numbers, an open string, an open
    // comment, a newline inside a string, a nul byte, and high byte values.
    send_item(OP_END, 8'hFF);
    send_text("#SeT x1 -2.5e+3;");
    send_item(OP_END, 0);
    send_text("\"ab\\");
    send_item(OP_END, 0);
    send_text("/*a*");
    send_item(OP_END, 0);
    send_text("\"q\n");
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, 8'd0);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_END, 0);

    // Random part: mostly well-formed fragments, some raw noise bytes.
    sent = 0;
    while (sent < 750) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(OP_END, 8'($urandom));
          sent++;
        end
        1, 2: begin
          send_item(OP_BYTE, ($urandom_range(0, 30) == 0) ? 8'd0 : 8'($urandom));
          sent++;
        end
        default: begin
          s = snippets[$urandom_range(0, snippets.size() - 1)];
          send_text(s);
          sent += s.len();
          if ($urandom_range(0, 1)) begin
            send_item(OP_BYTE, " ");
            sent++;
          end
        end
      endcase
    end
    send_item(OP_END, 0);
    in_if.valid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("PASS stage_text_tokenizer");
    else
      $display("FAIL stage_text_tokenizer");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL stage_text_tokenizer");
    $finish;
  end
endmodule
